/* src/msq_pkg.sv */
// Shared types, corner codes and offset tables for the marching-squares cell.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msq_pkg;

  localparam int INDEX_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF   = 32;

  // Four crossing lanes: segment 0 start and end, segment 1 start and end.
  localparam int LANES = 4;

  // Above-threshold bit of each corner.
  // Corner 0 = (i+1, j), 1 = (i+1, j+1), 2 = (i, j+1), 3 = (i, j).
  localparam logic [3:0] CODE_C0 = 4'h1;
  localparam logic [3:0] CODE_C1 = 4'h2;
  localparam logic [3:0] CODE_C2 = 4'h4;
  localparam logic [3:0] CODE_C3 = 4'h8;

  // Row and column offset of corner k, held in bit k.
  localparam logic [3:0] ROW_OFF = 4'b0011;
  localparam logic [3:0] COL_OFF = 4'b0110;

  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_ONE
  } mode_t;

  typedef struct packed {
    logic [1:0]                  nseg;
    logic [LANES-1:0][1:0]       ca;
    logic [LANES-1:0][1:0]       cb;
    mode_t [LANES-1:0]           mode;
  } ctl_t;

  // Picks the corner pairs of each crossing. A cut of corner g runs from
  // its edge towards h to its edge towards k.
  function automatic ctl_t sel_pairs(logic [3:0] code, logic below0, logic low);
    ctl_t c;
    c = '0;
    c.nseg = 2'd1;
    case (code)
      CODE_C0, 4'(~CODE_C0): begin
        c.ca[0] = 2'd0; c.cb[0] = 2'd1; c.ca[1] = 2'd0; c.cb[1] = 2'd3;
      end
      CODE_C1, 4'(~CODE_C1): begin
        c.ca[0] = 2'd1; c.cb[0] = 2'd0; c.ca[1] = 2'd1; c.cb[1] = 2'd2;
      end
      CODE_C2, 4'(~CODE_C2): begin
        c.ca[0] = 2'd2; c.cb[0] = 2'd3; c.ca[1] = 2'd2; c.cb[1] = 2'd1;
      end
      CODE_C3, 4'(~CODE_C3): begin
        c.ca[0] = 2'd3; c.cb[0] = 2'd2; c.ca[1] = 2'd3; c.cb[1] = 2'd0;
      end
      (CODE_C0 | CODE_C1), (CODE_C2 | CODE_C3): begin
        c.ca[0] = 2'd0; c.cb[0] = 2'd3; c.ca[1] = 2'd1; c.cb[1] = 2'd2;
      end
      (CODE_C1 | CODE_C2), (CODE_C0 | CODE_C3): begin
        c.ca[0] = 2'd0; c.cb[0] = 2'd1; c.ca[1] = 2'd3; c.cb[1] = 2'd2;
      end
      (CODE_C0 | CODE_C2), (CODE_C1 | CODE_C3): begin
        c.nseg = 2'd2;
        if (below0 && low) begin
          c.ca[0] = 2'd1; c.cb[0] = 2'd0; c.ca[1] = 2'd1; c.cb[1] = 2'd2;
          c.ca[2] = 2'd3; c.cb[2] = 2'd2; c.ca[3] = 2'd3; c.cb[3] = 2'd0;
        end else if (below0) begin
          c.ca[0] = 2'd2; c.cb[0] = 2'd3; c.ca[1] = 2'd2; c.cb[1] = 2'd1;
          c.ca[2] = 2'd0; c.cb[2] = 2'd1; c.ca[3] = 2'd0; c.cb[3] = 2'd3;
        end else if (low) begin
          c.ca[0] = 2'd0; c.cb[0] = 2'd1; c.ca[1] = 2'd0; c.cb[1] = 2'd3;
          c.ca[2] = 2'd2; c.cb[2] = 2'd3; c.ca[3] = 2'd2; c.cb[3] = 2'd1;
        end else begin
          c.ca[0] = 2'd3; c.cb[0] = 2'd2; c.ca[1] = 2'd3; c.cb[1] = 2'd0;
          c.ca[2] = 2'd1; c.cb[2] = 2'd0; c.ca[3] = 2'd1; c.cb[3] = 2'd2;
        end
      end
      default: c.nseg = 2'd0;
    endcase
    return c;
  endfunction

endpackage

/* src/msq_decode.sv */
// Front four stages: corner classification, pair selection, differences and
// magnitudes with saturation flags. Depends on msq_pkg.
`timescale 1ns / 1ps

module msq_decode
  import msq_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [INDEX_BITS-1:0]         in_row,
  input  logic [INDEX_BITS-1:0]         in_col,
  input  logic signed [SAMPLE_BITS-1:0] c00,
  input  logic signed [SAMPLE_BITS-1:0] c01,
  input  logic signed [SAMPLE_BITS-1:0] c10,
  input  logic signed [SAMPLE_BITS-1:0] c11,
  input  logic signed [SAMPLE_BITS-1:0] thr,
  input  logic signed [SAMPLE_BITS-1:0] nul,
  output logic                          out_v,
  output logic [INDEX_BITS-1:0]         out_row,
  output logic [INDEX_BITS-1:0]         out_col,
  output ctl_t                          out_ctl,
  output logic [SAMPLE_BITS-1:0]        out_n [LANES],
  output logic [SAMPLE_BITS-1:0]        out_d [LANES]
);

  localparam int S = SAMPLE_BITS;

  // Stage A: classification and corner sum.
  logic                 a_v_r;
  logic signed [S-1:0]  a_val_r [4];
  logic signed [S-1:0]  a_thr_r;
  logic [3:0]           a_code_r;
  logic                 a_null_r;
  logic signed [S+1:0]  a_sum_r;
  logic [INDEX_BITS-1:0] a_row_r, a_col_r;

  // Stage B: selected end values.
  logic                 b_v_r;
  logic signed [S-1:0]  b_va_r [LANES];
  logic signed [S-1:0]  b_vb_r [LANES];
  logic signed [S-1:0]  b_thr_r;
  ctl_t                 b_ctl_r;
  logic [INDEX_BITS-1:0] b_row_r, b_col_r;

  // Stage C: numerator and denominator.
  logic                 c_v_r;
  logic signed [S:0]    c_num_r [LANES];
  logic signed [S:0]    c_den_r [LANES];
  ctl_t                 c_ctl_r;
  logic [INDEX_BITS-1:0] c_row_r, c_col_r;

  // Stage D registers drive the outputs.
  logic                 d_v_r;
  logic [S-1:0]         d_n_r [LANES];
  logic [S-1:0]         d_d_r [LANES];
  ctl_t                 d_ctl_r;
  logic [INDEX_BITS-1:0] d_row_r, d_col_r;

  logic signed [S-1:0]  v_in [4];
  logic [3:0]           code_nxt;
  logic                 null_nxt;
  logic signed [S+1:0]  sum_nxt;
  logic                 low, below0;
  ctl_t                 ctl_b_nxt;
  ctl_t                 ctl_d_nxt;
  logic [S-1:0]         n_nxt [LANES];
  logic [S-1:0]         d_nxt [LANES];

  assign v_in[0] = c10;
  assign v_in[1] = c11;
  assign v_in[2] = c01;
  assign v_in[3] = c00;

  always_comb begin
    code_nxt = '0;
    null_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (v_in[k] == nul) null_nxt = 1'b1;
      code_nxt[k] = (v_in[k] > thr);
    end
    sum_nxt = (S+2)'(v_in[0]) + (S+2)'(v_in[1]) + (S+2)'(v_in[2]) + (S+2)'(v_in[3]);
  end

  always_comb begin
    low    = a_sum_r < $signed({a_thr_r, 2'b00});
    below0 = a_val_r[0] < a_thr_r;
    ctl_b_nxt = sel_pairs(a_code_r, below0, low);
    if (a_null_r) ctl_b_nxt.nseg = 2'd0;
  end

  always_comb begin
    ctl_d_nxt = c_ctl_r;
    for (int l = 0; l < LANES; l++) begin
      n_nxt[l] = c_num_r[l][S] ? S'(-c_num_r[l]) : S'(c_num_r[l]);
      d_nxt[l] = c_den_r[l][S] ? S'(-c_den_r[l]) : S'(c_den_r[l]);
      if (c_num_r[l] == '0 || c_den_r[l] == '0 || (c_num_r[l][S] != c_den_r[l][S]))
        ctl_d_nxt.mode[l] = MODE_ZERO;
      else if (n_nxt[l] >= d_nxt[l])
        ctl_d_nxt.mode[l] = MODE_ONE;
      else
        ctl_d_nxt.mode[l] = MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val_r  <= v_in;
      a_thr_r  <= thr;
      a_code_r <= code_nxt;
      a_null_r <= null_nxt;
      a_sum_r  <= sum_nxt;
      a_row_r  <= in_row;
      a_col_r  <= in_col;

      for (int l = 0; l < LANES; l++) begin
        b_va_r[l] <= a_val_r[ctl_b_nxt.ca[l]];
        b_vb_r[l] <= a_val_r[ctl_b_nxt.cb[l]];
      end
      b_thr_r <= a_thr_r;
      b_ctl_r <= ctl_b_nxt;
      b_row_r <= a_row_r;
      b_col_r <= a_col_r;

      for (int l = 0; l < LANES; l++) begin
        c_num_r[l] <= (S+1)'(b_thr_r) - (S+1)'(b_va_r[l]);
        c_den_r[l] <= (S+1)'(b_vb_r[l]) - (S+1)'(b_va_r[l]);
      end
      c_ctl_r <= b_ctl_r;
      c_row_r <= b_row_r;
      c_col_r <= b_col_r;

      d_n_r   <= n_nxt;
      d_d_r   <= d_nxt;
      d_ctl_r <= ctl_d_nxt;
      d_row_r <= c_row_r;
      d_col_r <= c_col_r;
    end
  end

  assign out_v   = d_v_r;
  assign out_row = d_row_r;
  assign out_col = d_col_r;
  assign out_ctl = d_ctl_r;
  assign out_n   = d_n_r;
  assign out_d   = d_d_r;

endmodule

/* src/msq_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Gives floor(n * 2^(F+1) / d) for n < d. Depends on msq_pkg.
`timescale 1ns / 1ps

module msq_divider
  import msq_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SAMPLE_BITS-1:0]   n_i [LANES],
  input  logic [SAMPLE_BITS-1:0]   d_i [LANES],
  output logic [FRACTION_BITS:0]   q_o [LANES]
);

  localparam int S      = SAMPLE_BITS;
  localparam int STAGES = FRACTION_BITS + 1;

  logic [S-1:0]           rem_r [STAGES][LANES];
  logic [S-1:0]           den_r [STAGES][LANES];
  logic [FRACTION_BITS:0] q_r   [STAGES][LANES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [S-1:0]           rem_in [LANES];
    logic [S-1:0]           den_in [LANES];
    logic [FRACTION_BITS:0] q_in   [LANES];
    logic [S:0]             dbl    [LANES];
    logic                   fit    [LANES];

    if (s == 0) begin : g_first
      assign rem_in = n_i;
      assign den_in = d_i;
      always_comb begin
        for (int l = 0; l < LANES; l++) q_in[l] = '0;
      end
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        dbl[l] = {rem_in[l], 1'b0};
        fit[l] = dbl[l] >= {1'b0, den_in[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= fit[l] ? S'(dbl[l] - {1'b0, den_in[l]}) : S'(dbl[l]);
          den_r[s][l] <= den_in[l];
          q_r[s][l]   <= {q_in[l][FRACTION_BITS-1:0], fit[l]};
        end
      end
    end
  end

  assign q_o = q_r[STAGES-1];

endmodule

/* src/marching_squares_cell.sv */
// Top level of the marching-squares cell: configuration registers, pipeline
// control, coordinate stage and output slot. Depends on msq_pkg, msq_decode
// and msq_divider.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid / in_stall) takes one grid cell per beat: its
// row and column and the four corner samples. The output channel
// (out_valid / out_stall) gives zero, one or two segment beats per cell, in
// order; out_last marks the final segment of a cell. Cells that are missing
// a corner, or that are wholly above or below the threshold, give no beat.
// Throughput is one cell per cycle while the receiver takes every beat; a
// saddle cell can hold the input while its second segment goes out, since
// the single output slot serves one beat per cycle.
// From input beat to first segment beat a cell passes four front stages,
// one restoring divider stage per quotient bit, a rounding and coordinate
// stage and the output slot.
// When the receiver stalls, the whole pipeline freezes as one once a result
// waits at its tail, so nothing is lost or repeated. Synchronous reset
// empties every stage and the output slot and loads the register defaults:
// threshold 0 and null value the most negative 32-bit number.
// Configuration: APB, threshold at address 0, null value at address 4.

module marching_squares_cell
  import msq_pkg::*;
#(
  parameter int INDEX_BITS    = INDEX_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [2:0]                              paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [INDEX_BITS-1:0]                   in_row,
  input  logic [INDEX_BITS-1:0]                   in_col,
  input  logic signed [SAMPLE_BITS-1:0]           in_corner_00,
  input  logic signed [SAMPLE_BITS-1:0]           in_corner_01,
  input  logic signed [SAMPLE_BITS-1:0]           in_corner_10,
  input  logic signed [SAMPLE_BITS-1:0]           in_corner_11,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [INDEX_BITS+FRACTION_BITS:0]       out_start_x,
  output logic [INDEX_BITS+FRACTION_BITS:0]       out_start_y,
  output logic [INDEX_BITS+FRACTION_BITS:0]       out_end_x,
  output logic [INDEX_BITS+FRACTION_BITS:0]       out_end_y,
  output logic                                    out_last
);

  localparam int S      = SAMPLE_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int CW     = INDEX_BITS + FRACTION_BITS + 1;
  localparam int STAGES = FRACTION_BITS + 1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_NULL      = 1'b1;

  typedef struct packed {
    logic                  v;
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    ctl_t                  ctl;
  } side_t;

  // Configuration registers keep all 32 bits; the datapath uses the low
  // SAMPLE_BITS bits, which are already the sign-extended sample format.
  logic [31:0] thr_r, nul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'h0000_0000;
      nul_r <= 32'h8000_0000;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_THRESHOLD: thr_r <= pwdata;
        REG_NULL:      nul_r <= pwdata;
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NULL) ? nul_r : thr_r;

  // The pipeline moves as a whole; it only halts when the tail holds a cell
  // with segments and the output slot cannot take it in this cycle.
  logic adv;

  logic                  dec_v;
  logic [INDEX_BITS-1:0] dec_row, dec_col;
  ctl_t                  dec_ctl;
  logic [S-1:0]          dec_n [LANES];
  logic [S-1:0]          dec_d [LANES];
  logic [F:0]            div_q [LANES];

  msq_decode #(
    .INDEX_BITS (INDEX_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_v   (in_valid),
    .in_row (in_row),
    .in_col (in_col),
    .c00    (in_corner_00),
    .c01    (in_corner_01),
    .c10    (in_corner_10),
    .c11    (in_corner_11),
    .thr    (thr_r[S-1:0]),
    .nul    (nul_r[S-1:0]),
    .out_v  (dec_v),
    .out_row(dec_row),
    .out_col(dec_col),
    .out_ctl(dec_ctl),
    .out_n  (dec_n),
    .out_d  (dec_d)
  );

  msq_divider #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk(clk),
    .en (adv),
    .n_i(dec_n),
    .d_i(dec_d),
    .q_o(div_q)
  );

  // Cell context travels alongside the divider, one entry per divider stage.
  side_t side_r [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) side_r[s].v <= 1'b0;
    end else if (adv) begin
      side_r[0] <= '{v: dec_v, row: dec_row, col: dec_col, ctl: dec_ctl};
      for (int s = 1; s < STAGES; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Rounding and coordinate stage.
  function automatic logic [CW-1:0] axis(logic [INDEX_BITS-1:0] base, logic oa,
                                         logic ob, logic [F:0] t);
    logic [INDEX_BITS:0] b1;
    b1 = {1'b0, base} + (INDEX_BITS+1)'(oa);
    if (oa == ob) return {b1, F'(0)};
    if (!oa) return {1'b0, base, F'(0)} + CW'(t);
    return {b1, F'(0)} - CW'(t);
  endfunction

  side_t        tail;
  logic [F:0]   t_val [LANES];
  logic [CW-1:0] x_nxt [LANES];
  logic [CW-1:0] y_nxt [LANES];
  logic [F+1:0] q_inc;

  assign tail = side_r[STAGES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // Round half away from zero: floor((q + 1) / 2) on the doubled quotient.
      q_inc = {1'b0, div_q[l]} + (F+2)'(1);
      case (tail.ctl.mode[l])
        MODE_ONE:  t_val[l] = {1'b1, F'(0)};
        MODE_ZERO: t_val[l] = '0;
        default:   t_val[l] = q_inc[F+1:1];
      endcase
      x_nxt[l] = axis(tail.col, COL_OFF[tail.ctl.ca[l]], COL_OFF[tail.ctl.cb[l]], t_val[l]);
      y_nxt[l] = axis(tail.row, ROW_OFF[tail.ctl.ca[l]], ROW_OFF[tail.ctl.cb[l]], t_val[l]);
    end
  end

  logic          r_v_r;
  logic [1:0]    r_nseg_r;
  logic [CW-1:0] r_x_r [LANES];
  logic [CW-1:0] r_y_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= tail.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_nseg_r <= tail.ctl.nseg;
      r_x_r    <= x_nxt;
      r_y_r    <= y_nxt;
    end
  end

  // Output slot: holds one cell's segments and sends them one beat at a time.
  logic          out_v_r, two_r, phase_r;
  logic [CW-1:0] o_x_r [LANES];
  logic [CW-1:0] o_y_r [LANES];
  logic          finishing, slot_free, load;

  assign finishing = phase_r || !two_r;
  assign slot_free = !out_v_r || (!out_stall && finishing);
  assign adv       = !r_v_r || (r_nseg_r == 2'd0) || slot_free;
  assign load      = r_v_r && (r_nseg_r != 2'd0) && slot_free;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (out_v_r && !out_stall) begin
      if (finishing) begin
        out_v_r <= 1'b0;
        phase_r <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      two_r <= (r_nseg_r == 2'd2);
      o_x_r <= r_x_r;
      o_y_r <= r_y_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_start_x = phase_r ? o_x_r[2] : o_x_r[0];
  assign out_start_y = phase_r ? o_y_r[2] : o_y_r[0];
  assign out_end_x   = phase_r ? o_x_r[3] : o_x_r[1];
  assign out_end_y   = phase_r ? o_y_r[3] : o_y_r[1];
  assign out_last    = finishing;

`ifndef SYNTHESIS
  // The second beat is only ever sent for a two-segment cell.
  a_phase_two : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && phase_r) |-> two_r)
    else $error("second segment beat without a saddle cell");

  // The input is only held off while a result waits in the output slot.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_v_r && r_v_r && r_nseg_r != 2'd0))
    else $error("input stalled with no pending result");

  // A held result beat must survive a stall unchanged.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(phase_r) && $stable(out_start_x)))
    else $error("output beat changed while stalled");

  // After reset nothing is offered.
  a_reset : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule

/* verif/marching_squares_cell_tb.sv */
// Self-checking testbench for the marching-squares cell: APB register writes,
// directed and random grid cells under varied idling, segments checked in order.
// Depends on msq_pkg and the marching_squares_cell RTL only.
`timescale 1ns / 1ps

module marching_squares_cell_tb;
  import msq_pkg::*;

  localparam int IB = INDEX_BITS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CW = IB + FB + 1;
  localparam longint unsigned ONE_FX = 64'd1 << FB;
  localparam longint unsigned CMASK = (64'd1 << CW) - 1;
  // Pause after the last expected segment, long enough for every stage to
  // empty, before touching the registers.
  localparam int SETTLE = FB + 20;
  localparam int LIMIT = 600000;
  localparam int HOLD_LEN = 300;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [2:0] ADDR_NULL_VALUE = 3'd4;
  localparam longint SMAX = 2147483647;
  localparam longint SMIN = -64'sd2147483648;

  typedef struct {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic last;
  } segment_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IB-1:0] in_row = '0;
  logic [IB-1:0] in_col = '0;
  logic signed [SB-1:0] in_corner_00 = '0;
  logic signed [SB-1:0] in_corner_01 = '0;
  logic signed [SB-1:0] in_corner_10 = '0;
  logic signed [SB-1:0] in_corner_11 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CW-1:0] out_start_x;
  logic [CW-1:0] out_start_y;
  logic [CW-1:0] out_end_x;
  logic [CW-1:0] out_end_y;
  logic out_last;

  marching_squares_cell i_dut (.*);

  // The testbench's own copy of the two registers.
  logic signed [31:0] thr_reg = '0;
  logic signed [31:0] null_reg = 32'sh8000_0000;

  segment_t seg_q[$];
  int fail_count = 0;
  int cells_sent = 0;
  int segs_seen = 0;
  int saddles_seen = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;

  // Working values for the segment predictor, set once per cell.
  longint cv[4];
  longint cthr;
  longint unsigned crow, ccol;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Cycle counter; a run that reaches the limit has hung somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", LIMIT, seg_q.size());
      $display("** marching_squares_cell: FAILED **");
      $finish;
    end
  end

  // Receiver: either a long forced hold-off, counted down here, or random stalls.
  // A new hold-off starts whenever the request count moves on.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Crossing fraction on the edge from a sample va to vb, rounded to nearest
  // and clamped to [0, 1].
  function automatic longint unsigned edge_fraction(longint va, longint vb);
    longint num, den;
    longint unsigned n, d;
    num = cthr - va;
    den = vb - va;
    if (den == 0 || num == 0) return 0;
    if ((num < 0) != (den < 0)) return 0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (n >= d) return ONE_FX;
    return ((n << (FB + 1)) + d) / (2 * d);
  endfunction

  function automatic longint unsigned along(longint unsigned base, logic oa, logic ob,
                                            longint unsigned t);
    if (oa == ob) return (base + oa) << FB;
    if (!oa) return (base << FB) + t;
    return ((base + 1) << FB) - t;
  endfunction

  function automatic void crossing_at(int a, int b, output logic [CW-1:0] x,
                                      output logic [CW-1:0] y);
    longint unsigned t;
    t = edge_fraction(cv[a], cv[b]);
    x = CW'(along(ccol, COL_OFF[a], COL_OFF[b], t) & CMASK);
    y = CW'(along(crow, ROW_OFF[a], ROW_OFF[b], t) & CMASK);
  endfunction

  // Queues the segment from crossing a-b to crossing c-d.
  function automatic void push_segment(int a, int b, int c, int d, logic last);
    segment_t s;
    crossing_at(a, b, s.sx, s.sy);
    crossing_at(c, d, s.ex, s.ey);
    s.last = last;
    seg_q.insert(seg_q.size(), s);
  endfunction

  // Works out the segments of one accepted cell. Corner k follows the block's
  // numbering: 0 lower-left, 1 lower-right, 2 upper-right, 3 upper-left.
  function automatic void predict_cell(logic [IB-1:0] r, logic [IB-1:0] c,
                                       logic signed [SB-1:0] c00, logic signed [SB-1:0] c01,
                                       logic signed [SB-1:0] c10, logic signed [SB-1:0] c11);
    logic [3:0] code;
    logic low, below0;
    code = '0;
    cv[0] = longint'(c10); cv[1] = longint'(c11); cv[2] = longint'(c01); cv[3] = longint'(c00);
    cthr = longint'(thr_reg);
    crow = 64'(r);
    ccol = 64'(c);
    for (int k = 0; k < 4; k++) begin
      if (cv[k] == longint'(null_reg)) return;
      if (cv[k] > cthr) code[k] = 1'b1;
    end
    case (code)
      CODE_C0, 4'(~CODE_C0): push_segment(0, 1, 0, 3, 1'b1);
      CODE_C1, 4'(~CODE_C1): push_segment(1, 0, 1, 2, 1'b1);
      CODE_C2, 4'(~CODE_C2): push_segment(2, 3, 2, 1, 1'b1);
      CODE_C3, 4'(~CODE_C3): push_segment(3, 2, 3, 0, 1'b1);
      (CODE_C0 | CODE_C1), (CODE_C2 | CODE_C3): push_segment(0, 3, 1, 2, 1'b1);
      (CODE_C1 | CODE_C2), (CODE_C0 | CODE_C3): push_segment(0, 1, 3, 2, 1'b1);
      (CODE_C0 | CODE_C2), (CODE_C1 | CODE_C3): begin
        // Saddle: the mean against the level and the lower-left corner decide
        // which pair of corners is cut off.
        low = (cv[0] + cv[1] + cv[2] + cv[3]) < 4 * cthr;
        below0 = cv[0] < cthr;
        saddles_seen++;
        if (below0 && low) begin
          push_segment(1, 0, 1, 2, 1'b0);
          push_segment(3, 2, 3, 0, 1'b1);
        end else if (below0) begin
          push_segment(2, 3, 2, 1, 1'b0);
          push_segment(0, 1, 0, 3, 1'b1);
        end else if (low) begin
          push_segment(0, 1, 0, 3, 1'b0);
          push_segment(2, 3, 2, 1, 1'b1);
        end else begin
          push_segment(3, 2, 3, 0, 1'b0);
          push_segment(1, 0, 1, 2, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Segment checker: every accepted output beat against the oldest expectation.
  always @(posedge clk) begin
    segment_t s;
    if (rst_n && out_valid && !out_stall) begin
      segs_seen++;
      if (seg_q.size() == 0) begin
        $error("segment beat with nothing expected");
        fail_count++;
      end else begin
        s = seg_q.pop_front();
        if (out_start_x !== s.sx) begin
          $error("start_x expected %0h got %0h", s.sx, out_start_x); fail_count++;
        end
        if (out_start_y !== s.sy) begin
          $error("start_y expected %0h got %0h", s.sy, out_start_y); fail_count++;
        end
        if (out_end_x !== s.ex) begin
          $error("end_x expected %0h got %0h", s.ex, out_end_x); fail_count++;
        end
        if (out_end_y !== s.ey) begin
          $error("end_y expected %0h got %0h", s.ey, out_end_y); fail_count++;
        end
        if (out_last !== s.last) begin
          $error("last expected %0b got %0b", s.last, out_last); fail_count++;
        end
      end
    end
  end

  // Offers one cell, possibly after a random gap, and returns at the edge that
  // accepts it. in_valid stays high into the next call unless a gap is drawn.
  task automatic send_cell(logic [IB-1:0] r, logic [IB-1:0] c, longint c00, longint c01,
                           longint c10, longint c11);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row <= r;
    in_col <= c;
    in_corner_00 <= c00[SB-1:0];
    in_corner_01 <= c01[SB-1:0];
    in_corner_10 <= c10[SB-1:0];
    in_corner_11 <= c11[SB-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cell(r, c, c00[SB-1:0], c01[SB-1:0], c10[SB-1:0], c11[SB-1:0]);
    cells_sent++;
  endtask

  // Drops valid, waits for every outstanding segment and lets the pipe empty.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (seg_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_THRESHOLD) thr_reg = value;
    else null_reg = value;
    @(posedge clk);
  endtask

  function automatic longint clamp32(longint v);
    return (v > SMAX) ? SMAX : (v < SMIN) ? SMIN : v;
  endfunction

  // Mostly samples near the level so that crossings and saddles are common;
  // some fully random, a few hitting the null marker.
  function automatic longint pick_sample();
    int m;
    m = $urandom_range(99);
    if (m < 70) return clamp32(longint'(thr_reg) + $signed($urandom_range(2000)) - 1000);
    if (m < 95) return longint'($signed($urandom()));
    return longint'(null_reg);
  endfunction

  task automatic send_random(int count);
    logic [IB-1:0] r, c;
    repeat (count) begin
      r = ($urandom_range(9) == 0) ? {IB{1'b1}} : IB'($urandom());
      c = ($urandom_range(9) == 0) ? '0 : IB'($urandom());
      send_cell(r, c, pick_sample(), pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  // Reset values, fourteen of the sixteen corner patterns, each saddle branch, the null marker,
  // equal samples and the extremes of the fields.
  task automatic test_directed_cells;
    send_cell(0, 0, 5, -5, -5, -5);
    send_cell(1, 2, -5, 5, -5, -5);
    send_cell(3, 4, -5, -5, 5, -5);
    send_cell(5, 6, -5, -5, -5, 5);
    send_cell(7, 8, 5, 5, -5, -5);
    send_cell(9, 10, 5, -5, 5, -5);
    send_cell(4095, 4095, -5, 5, -5, 5);
    send_cell(4095, 0, -5, -5, 5, 5);
    send_cell(0, 4095, 5, 5, 5, -5);
    send_cell(11, 12, 3, 3, 3, 3);
    send_cell(13, 14, 0, 0, 0, 0);
    // Saddles: each combination of the mean and the lower-left corner.
    send_cell(20, 20, -10, 10, 10, -10);
    send_cell(20, 21, -30, 10, 10, -30);
    send_cell(21, 20, 10, -10, -10, 10);
    send_cell(21, 21, 5, -10, -10, 5);
    // Extremes: saturated fractions and the most negative value as null.
    send_cell(4095, 4095, SMAX, SMIN + 1, SMIN + 1, SMAX);
    send_cell(100, 200, SMAX, SMAX, SMIN + 1, SMAX);
    send_cell(100, 201, SMIN, 5, 5, 5);
    send_cell(1, 1, 0, 7, -7, 0);
    send_cell(2, 2, 1, -1, 1, -1);
    drain();
  endtask

  // Several register settings, the extremes among them, each with random cells.
  task automatic test_register_settings;
    write_reg(ADDR_NULL_VALUE, 32'sd7);
    write_reg(ADDR_THRESHOLD, 32'sd100);
    send_cell(0, 0, 7, 200, 0, 0);
    send_cell(0, 1, 200, 0, 0, 0);
    send_cell(0, 2, SMIN, 200, 200, 200);
    send_random(40);
    drain();
    write_reg(ADDR_THRESHOLD, 32'h7FFF_FFFF);
    write_reg(ADDR_NULL_VALUE, 32'h7FFF_FFFF);
    send_random(30);
    drain();
    write_reg(ADDR_THRESHOLD, 32'h8000_0000);
    write_reg(ADDR_NULL_VALUE, 32'h0);
    send_random(30);
    drain();
    write_reg(ADDR_THRESHOLD, 32'hFFFF_C000);
    write_reg(ADDR_NULL_VALUE, 32'h8000_0000);
    send_random(40);
    drain();
  endtask

  // Random cells through each idling mix, with a fresh level for each.
  task automatic test_idling_phases;
    int idle_mix[4] = '{0, 63, 0, 18};
    int stall_mix[4] = '{0, 0, 63, 18};
    for (int p = 0; p < 4; p++) begin
      write_reg(ADDR_THRESHOLD, $urandom());
      sender_idle_pct = idle_mix[p];
      stall_pct = stall_mix[p];
      send_random(125);
      drain();
    end
  endtask

  // A long receiver hold-off while cells keep coming, so that the pipeline
  // fills and the input stalls; then a full stop until every segment is back.
  task automatic test_backpressure;
    sender_idle_pct = 0;
    stall_pct = 10;
    hold_req++;
    send_random(60);
    in_valid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk);
    send_random(60);
    drain();
    stall_pct = 30;
    sender_idle_pct = 30;
    send_random(70);
    drain();
  endtask

  initial begin
    @(posedge rst_n);
    @(posedge clk);
    test_directed_cells();
    test_register_settings();
    test_idling_phases();
    test_backpressure();
    if (seg_q.size() != 0) begin
      $error("%0d expected segments never arrived", seg_q.size());
      fail_count++;
    end
    $display("Sent %0d cells (%0d saddles) over several levels and idling mixes.",
             cells_sent, saddles_seen);
    $display("Checked %0d segment beats, %0d mismatches.", segs_seen, fail_count);
    if (fail_count == 0) begin
      $display("** marching_squares_cell: PASSED **");
    end else begin
      $display("** marching_squares_cell: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/msq_pkg.sv
src/msq_decode.sv
src/msq_divider.sv
src/marching_squares_cell.sv
verif/marching_squares_cell_tb.sv
